// ----- rtl/core/msc_pkg.sv -----
`default_nettype none

package msc_pkg;

   // default sizing for the top level parameters
   localparam int MAX_ITEMS_DEF  = 64;
   localparam int KEY_WIDTH_DEF  = 32;

   // fixed field widths of the stream ports
   localparam int KEY_PORT_WIDTH = 32;
   localparam int COUNT_WIDTH    = 12;
   localparam int RSP_DATA_WIDTH = KEY_PORT_WIDTH + 2 * COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // operation counts kept by the sorter
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] moves;
      logic [COUNT_WIDTH-1:0] compares;
   } sort_counts_type;

   typedef enum logic [1:0] {
      TOP_LOAD,
      TOP_SORT,
      TOP_EMIT_FIRST,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      SRT_IDLE,
      SRT_POP,
      SRT_COPY,
      SRT_HEAD_A,
      SRT_HEAD_B,
      SRT_MERGE
   } sort_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/merge_sort_with_counts_top.sv -----
`default_nettype none

// sequence: keys are taken back to back while loading; after the last key, the merge sort runs
//   (per merged range: a split and a later merge pop on the stack, a copy of the range, two head
//   reads, then one move per cycle; a single-key range is only popped from the stack), then the
//   first key is read from memory, then results stream at one per cycle while rsp_tready is high
// sets: one at a time; no new key is taken until the last result of the set is taken
// reset: synchronous, clears the control state, counts and flag; memories keep their contents
module merge_sort_with_counts_top #(
   parameter int MaxItems = msc_pkg::MAX_ITEMS_DEF,
   parameter int KeyWidth = msc_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input stream
   input  wire logic [msc_pkg::KEY_PORT_WIDTH-1:0]   req_tdata,   // key
   input  wire logic                                 req_tlast,   // final_key
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // result stream
   output logic      [msc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,   // sorted_key, compare_count, move_count
   output logic                                      rsp_tuser,   // overflow
   output logic                                      rsp_tlast,   // final_out
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready
);

   localparam int IdxWidth   = $clog2(MaxItems);
   localparam int CountWidth = $clog2(MaxItems + 1);

   msc_pkg::top_state_type state_ff, state_in;

   // keys held for the current set, and the output pointer
   logic [CountWidth-1:0] item_count_ff, item_count_in;
   logic [IdxWidth-1:0]   emit_idx_ff, emit_idx_in;
   logic                  overflow_ff, overflow_in;

   logic                  req_xfer, rsp_xfer, emit_last, set_full;
   logic [CountWidth-1:0] emit_idx_ext;

   // key memory port as driven by load and emit
   logic                  ld_we, ld_re;
   logic [IdxWidth-1:0]   ld_waddr, ld_raddr;
   logic [KeyWidth-1:0]   ld_wdata;
   logic [63:0]           key_ext;
   logic signed [63:0]    key_out;

   // key memory port after the sort/io select
   logic                  st_we, st_re;
   logic [IdxWidth-1:0]   st_waddr, st_raddr;
   logic [KeyWidth-1:0]   st_wdata, st_rdata;

   // sorter side
   logic                     sort_start, sort_done;
   msc_pkg::sort_counts_type sort_counts;
   logic                     srt_st_we, srt_st_re;
   logic [IdxWidth-1:0]      srt_st_waddr, srt_st_raddr;
   logic [KeyWidth-1:0]      srt_st_wdata;
   logic                     sc_we, sc_re;
   logic [IdxWidth-1:0]      sc_waddr, sc_raddr;
   logic [KeyWidth-1:0]      sc_wdata, sc_rdata;

   assign req_xfer     = req_tvalid && req_tready;
   assign rsp_xfer     = rsp_tvalid && rsp_tready;
   assign set_full     = (item_count_ff >= CountWidth'(MaxItems));
   assign emit_idx_ext = CountWidth'(emit_idx_ff);
   assign emit_last    = ((emit_idx_ext + CountWidth'(1)) == item_count_ff);

   // keys are kept at KeyWidth bits; narrower keys are sign-extended on the way out
   assign key_ext  = {{(64 - msc_pkg::KEY_PORT_WIDTH){1'b0}}, req_tdata};
   assign ld_wdata = key_ext[KeyWidth-1:0];
   assign ld_waddr = item_count_ff[IdxWidth-1:0];
   assign key_out  = 64'(signed'(st_rdata));

   // result fields: key from the memory read register, counts held by the sorter
   assign rsp_tdata = {sort_counts.moves, sort_counts.compares,
                       key_out[msc_pkg::KEY_PORT_WIDTH-1:0]};
   assign rsp_tuser = overflow_ff;
   assign rsp_tlast = emit_last;

   // the sorter owns the key memory only while sorting
   always_comb begin
      if (state_ff == msc_pkg::TOP_SORT) begin
         st_we    = srt_st_we;
         st_waddr = srt_st_waddr;
         st_wdata = srt_st_wdata;
         st_re    = srt_st_re;
         st_raddr = srt_st_raddr;
      end else begin
         st_we    = ld_we;
         st_waddr = ld_waddr;
         st_wdata = ld_wdata;
         st_re    = ld_re;
         st_raddr = ld_raddr;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msc_pkg::TOP_LOAD: begin
            if (req_xfer && req_tlast) begin
               state_in = msc_pkg::TOP_SORT;
            end
         end
         msc_pkg::TOP_SORT: begin
            if (sort_done) begin
               state_in = msc_pkg::TOP_EMIT_FIRST;
            end
         end
         msc_pkg::TOP_EMIT_FIRST: state_in = msc_pkg::TOP_EMIT;
         msc_pkg::TOP_EMIT: begin
            if (rsp_xfer && emit_last) begin
               state_in = msc_pkg::TOP_LOAD;
            end
         end
         default: state_in = msc_pkg::TOP_LOAD;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      sort_start    = 1'b0;
      ld_we         = 1'b0;
      ld_re         = 1'b0;
      ld_raddr      = '0;
      item_count_in = item_count_ff;
      emit_idx_in   = emit_idx_ff;
      overflow_in   = overflow_ff;
      case (state_ff)
         msc_pkg::TOP_LOAD: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               // first key of a set clears the flag; counts clear when the sort starts
               if (item_count_ff == '0) begin
                  overflow_in = 1'b0;
               end
               if (!set_full) begin
                  ld_we         = 1'b1;
                  item_count_in = item_count_ff + CountWidth'(1);
               end else begin
                  // key past capacity is dropped
                  overflow_in = 1'b1;
               end
               sort_start = req_tlast;
            end
         end
         msc_pkg::TOP_SORT: begin
            emit_idx_in = '0;
         end
         msc_pkg::TOP_EMIT_FIRST: begin
            ld_re       = 1'b1;
            ld_raddr    = '0;
            emit_idx_in = '0;
         end
         msc_pkg::TOP_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_xfer) begin
               if (emit_last) begin
                  item_count_in = '0;
               end else begin
                  // fetch the next key so it shows right after this transfer
                  emit_idx_in = emit_idx_ff + IdxWidth'(1);
                  ld_re       = 1'b1;
                  ld_raddr    = emit_idx_ff + IdxWidth'(1);
               end
            end
         end
         default: begin
            item_count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msc_pkg::TOP_LOAD;
         item_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
   end

   msc_sorter #(
      .MaxItems (MaxItems),
      .KeyWidth (KeyWidth)
   ) u_sorter (
      .clock         (clock),
      .reset         (reset),
      .start         (sort_start),
      .n_items       (item_count_in),
      .done          (sort_done),
      .counts        (sort_counts),
      .store_re      (srt_st_re),
      .store_raddr   (srt_st_raddr),
      .store_rdata   (st_rdata),
      .store_we      (srt_st_we),
      .store_waddr   (srt_st_waddr),
      .store_wdata   (srt_st_wdata),
      .scratch_re    (sc_re),
      .scratch_raddr (sc_raddr),
      .scratch_rdata (sc_rdata),
      .scratch_we    (sc_we),
      .scratch_waddr (sc_waddr),
      .scratch_wdata (sc_wdata)
   );

   // key store
   msc_ram #(
      .Width (KeyWidth),
      .Depth (MaxItems)
   ) u_key_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   // merge scratch
   msc_ram #(
      .Width (KeyWidth),
      .Depth (MaxItems)
   ) u_scratch_ram (
      .clock (clock),
      .we    (sc_we),
      .waddr (sc_waddr),
      .wdata (sc_wdata),
      .re    (sc_re),
      .raddr (sc_raddr),
      .rdata (sc_rdata)
   );

endmodule

`default_nettype wire

// ----- rtl/core/msc_ram.sv -----
`default_nettype none

module msc_ram #(
   parameter int Width = 32,
   parameter int Depth = 64,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AddrWidth-1:0] waddr,
   input  wire logic [Width-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [AddrWidth-1:0] raddr,
   output logic      [Width-1:0]     rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/msc_sorter.sv -----
`default_nettype none

module msc_sorter #(
   parameter int MaxItems = msc_pkg::MAX_ITEMS_DEF,
   parameter int KeyWidth = msc_pkg::KEY_WIDTH_DEF,
   localparam int IdxWidth   = $clog2(MaxItems),
   localparam int CountWidth = $clog2(MaxItems + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [CountWidth-1:0]   n_items,
   output logic                         done,
   output msc_pkg::sort_counts_type     counts,
   // key store port
   output logic                         store_re,
   output logic      [IdxWidth-1:0]     store_raddr,
   input  wire logic [KeyWidth-1:0]     store_rdata,
   output logic                         store_we,
   output logic      [IdxWidth-1:0]     store_waddr,
   output logic      [KeyWidth-1:0]     store_wdata,
   // scratch port
   output logic                         scratch_re,
   output logic      [IdxWidth-1:0]     scratch_raddr,
   input  wire logic [KeyWidth-1:0]     scratch_rdata,
   output logic                         scratch_we,
   output logic      [IdxWidth-1:0]     scratch_waddr,
   output logic      [KeyWidth-1:0]     scratch_wdata
);

   // each split level leaves at most a pending merge and a right sibling
   localparam int StackDepth = 2 * IdxWidth + 1;
   localparam int StkIdxW    = $clog2(StackDepth);
   localparam int SpWidth    = $clog2(StackDepth + 1);
   localparam int CntW       = msc_pkg::COUNT_WIDTH;

   msc_pkg::sort_state_type state_ff, state_in;

   logic [SpWidth-1:0]    sp_ff, sp_in;
   logic [IdxWidth-1:0]   stk_lo_ff [StackDepth];
   logic [IdxWidth-1:0]   stk_hi_ff [StackDepth];
   logic                  stk_ph_ff [StackDepth];
   logic                  stk_init, stk_push;

   logic [IdxWidth-1:0]   lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [IdxWidth-1:0]   t_ff, t_in;
   logic                  pend_ff, pend_in;
   logic [IdxWidth-1:0]   pend_addr_ff, pend_addr_in;
   logic [CountWidth-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [KeyWidth-1:0]   head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic                  ref_a_ff, ref_a_in, ref_b_ff, ref_b_in;
   logic [CntW-1:0]       cmp_ff, cmp_in, mov_ff, mov_in;

   logic [SpWidth-1:0]    sp_dec, sp_inc;
   logic [StkIdxW-1:0]    top_idx, push_idx1, push_idx2;
   logic [IdxWidth-1:0]   top_lo, top_hi, top_mid, top_span;
   logic                  top_ph;
   logic [KeyWidth-1:0]   cur_a, cur_b;
   logic                  a_live, b_live, take_a, last_move;
   logic [CountWidth-1:0] a_next, b_next, hi_ext, mid_ext;
   logic [CountWidth-1:0] n_last;

   // top of stack
   assign sp_dec    = sp_ff - SpWidth'(1);
   assign sp_inc    = sp_ff + SpWidth'(1);
   assign top_idx   = sp_dec[StkIdxW-1:0];
   assign push_idx1 = sp_ff[StkIdxW-1:0];
   assign push_idx2 = sp_inc[StkIdxW-1:0];
   assign top_lo    = stk_lo_ff[top_idx];
   assign top_hi    = stk_hi_ff[top_idx];
   assign top_ph    = stk_ph_ff[top_idx];
   assign top_span  = top_hi - top_lo;
   assign top_mid   = top_lo + (top_span >> 1);
   assign n_last    = n_items - CountWidth'(1);

   // run heads come from the ram right after a refill, else from the holding register
   assign cur_a     = ref_a_ff ? scratch_rdata : head_a_ff;
   assign cur_b     = ref_b_ff ? scratch_rdata : head_b_ff;
   assign hi_ext    = CountWidth'(hi_ff);
   assign mid_ext   = CountWidth'(mid_ff);
   assign a_live    = (a_ff <= mid_ext);
   assign b_live    = (b_ff <= hi_ext);
   assign take_a    = a_live && (!b_live || ($signed(cur_a) <= $signed(cur_b)));
   assign a_next    = a_ff + CountWidth'(1);
   assign b_next    = b_ff + CountWidth'(1);
   assign last_move = (k_ff == hi_ext);

   // copy write-back comes in the cycle after the store read
   assign scratch_we    = pend_ff;
   assign scratch_waddr = pend_addr_ff;
   assign scratch_wdata = store_rdata;
   assign counts.compares = cmp_ff;
   assign counts.moves    = mov_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msc_pkg::SRT_IDLE: begin
            if (start) begin
               state_in = msc_pkg::SRT_POP;
            end
         end
         msc_pkg::SRT_POP: begin
            if (sp_ff == '0) begin
               state_in = msc_pkg::SRT_IDLE;
            end else if (top_ph && (top_lo < top_hi)) begin
               state_in = msc_pkg::SRT_COPY;
            end
         end
         msc_pkg::SRT_COPY: begin
            if (t_ff == hi_ff) begin
               state_in = msc_pkg::SRT_HEAD_A;
            end
         end
         msc_pkg::SRT_HEAD_A: state_in = msc_pkg::SRT_HEAD_B;
         msc_pkg::SRT_HEAD_B: state_in = msc_pkg::SRT_MERGE;
         msc_pkg::SRT_MERGE: begin
            if (last_move) begin
               state_in = msc_pkg::SRT_POP;
            end
         end
         default: state_in = msc_pkg::SRT_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      done          = 1'b0;
      stk_init      = 1'b0;
      stk_push      = 1'b0;
      sp_in         = sp_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      t_in          = t_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      head_a_in     = head_a_ff;
      head_b_in     = head_b_ff;
      ref_a_in      = ref_a_ff;
      ref_b_in      = ref_b_ff;
      cmp_in        = cmp_ff;
      mov_in        = mov_ff;
      store_re      = 1'b0;
      store_raddr   = t_ff;
      store_we      = 1'b0;
      store_waddr   = k_ff[IdxWidth-1:0];
      store_wdata   = take_a ? cur_a : cur_b;
      scratch_re    = 1'b0;
      scratch_raddr = lo_ff;
      case (state_ff)
         msc_pkg::SRT_IDLE: begin
            if (start) begin
               stk_init = 1'b1;
               sp_in    = SpWidth'(1);
               cmp_in   = '0;
               mov_in   = '0;
            end
         end
         msc_pkg::SRT_POP: begin
            if (sp_ff == '0) begin
               done = 1'b1;
            end else if (top_lo >= top_hi) begin
               sp_in = sp_dec;
            end else if (!top_ph) begin
               // split: merge marker, then right half, then left half on top
               stk_push = 1'b1;
               sp_in    = sp_ff + SpWidth'(2);
            end else begin
               sp_in  = sp_dec;
               lo_in  = top_lo;
               mid_in = top_mid;
               hi_in  = top_hi;
               t_in   = top_lo;
            end
         end
         msc_pkg::SRT_COPY: begin
            store_re     = 1'b1;
            store_raddr  = t_ff;
            pend_in      = 1'b1;
            pend_addr_in = t_ff;
            t_in         = t_ff + IdxWidth'(1);
         end
         msc_pkg::SRT_HEAD_A: begin
            scratch_re    = 1'b1;
            scratch_raddr = lo_ff;
         end
         msc_pkg::SRT_HEAD_B: begin
            scratch_re    = 1'b1;
            scratch_raddr = mid_ff + IdxWidth'(1);
            head_a_in     = scratch_rdata;
            ref_a_in      = 1'b0;
            ref_b_in      = 1'b1;
            a_in          = CountWidth'(lo_ff);
            b_in          = mid_ext + CountWidth'(1);
            k_in          = CountWidth'(lo_ff);
         end
         msc_pkg::SRT_MERGE: begin
            store_we  = 1'b1;
            k_in      = k_ff + CountWidth'(1);
            head_a_in = cur_a;
            head_b_in = cur_b;
            if (a_live && b_live && (cmp_ff != msc_pkg::COUNT_MAX)) begin
               cmp_in = cmp_ff + CntW'(1);
            end
            if (mov_ff != msc_pkg::COUNT_MAX) begin
               mov_in = mov_ff + CntW'(1);
            end
            scratch_re = 1'b1;
            if (take_a) begin
               a_in          = a_next;
               scratch_raddr = a_next[IdxWidth-1:0];
               ref_a_in      = 1'b1;
               ref_b_in      = 1'b0;
            end else begin
               b_in          = b_next;
               scratch_raddr = b_next[IdxWidth-1:0];
               ref_a_in      = 1'b0;
               ref_b_in      = 1'b1;
            end
         end
         default: begin
            sp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msc_pkg::SRT_IDLE;
         sp_ff    <= '0;
         pend_ff  <= 1'b0;
         cmp_ff   <= '0;
         mov_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         pend_ff  <= pend_in;
         cmp_ff   <= cmp_in;
         mov_ff   <= mov_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      t_ff         <= t_in;
      pend_addr_ff <= pend_addr_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      head_a_ff    <= head_a_in;
      head_b_ff    <= head_b_in;
      ref_a_ff     <= ref_a_in;
      ref_b_ff     <= ref_b_in;
      if (stk_init) begin
         stk_lo_ff[0] <= '0;
         stk_hi_ff[0] <= n_last[IdxWidth-1:0];
         stk_ph_ff[0] <= 1'b0;
      end
      if (stk_push) begin
         stk_ph_ff[top_idx]   <= 1'b1;
         stk_lo_ff[push_idx1] <= top_mid + IdxWidth'(1);
         stk_hi_ff[push_idx1] <= top_hi;
         stk_ph_ff[push_idx1] <= 1'b0;
         stk_lo_ff[push_idx2] <= top_lo;
         stk_hi_ff[push_idx2] <= top_mid;
         stk_ph_ff[push_idx2] <= 1'b0;
      end
   end

endmodule

`default_nettype wire
